/* sv/fpc_pkg.sv */
// Shared constants, types and elaboration-time tables for the frictional pressure unit.
// No dependencies; every other file in this folder imports it.
`timescale 1ns / 1ps

package fpc_pkg;

  // Field widths
  localparam int FracW   = 16;
  localparam int WideW   = 48;
  localparam int RhoW    = 24;
  localparam int FricW   = 32;
  localparam int InW     = 120;
  localparam int OutW    = 144;
  localparam int CfgIdxW = 3;
  localparam int CfgW    = 32;

  // Log domain: raw log2 is 5 integer bits and 16 fraction bits
  localparam int LogRawW = 21;
  localparam int LogW    = 24;
  localparam int ExpW    = 28;
  localparam int ProdW   = 41;
  localparam int XW      = 22;

  localparam logic [WideW-1:0] OutMax = {WideW{1'b1}};
  localparam logic [15:0]      OneQ12 = 16'd4096;

  // Offsets in the log domain (Q.16)
  localparam logic signed [LogW-1:0] Shift16 = LogW'(16 * 65536);
  localparam logic signed [LogW-1:0] Shift12 = LogW'(12 * 65536);
  localparam logic signed [ExpW-1:0] ExpHi   = ExpW'(32 * 65536);
  localparam logic signed [ExpW-1:0] ExpLo   = -ExpW'(16 * 65536);

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgFric   = 3'd0,
    CfgEta    = 3'd1,
    CfgP      = 3'd2,
    CfgMinGap = 3'd3,
    CfgOnset  = 3'd4,
    CfgSine   = 3'd5
  } cfg_idx_e;

  // Per-item flags carried along the pipeline
  typedef struct packed {
    logic diff_pos;
    logic alpha_pos;
    logic d_zero;
    logic d_neg;
  } flags_t;

  // Control carried through an exp2 lane
  typedef struct packed {
    logic sat;
    logic zero;
    logic keep;
  } exp_ctl_t;

  // Integer square root, bit by bit (elaboration only)
  function automatic logic [63:0] isqrt64(input logic [63:0] n);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bit_v;
    rem   = n;
    res   = '0;
    bit_v = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bit_v) begin
        rem = rem - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  // Entry k of the 2^(2^-k) table in Q1.31
  function automatic logic [31:0] rom_entry(input int k);
    logic [63:0] v;
    v = isqrt64(64'd1 << 63);
    for (int j = 2; j <= 16; j++) begin
      if (j <= k) begin
        v = isqrt64(v << 31);
      end
    end
    return v[31:0];
  endfunction

endpackage

/* sv/fpc_log2.sv */
// Pipelined base-2 logarithm lane: normalise, then one squaring per stage.
// Depends on fpc_pkg.
`timescale 1ns / 1ps

module fpc_log2 (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [31:0]                 n_i,
  output logic [fpc_pkg::LogRawW-1:0] r_o
);
  import fpc_pkg::*;

  logic [31:0]        m_q [0:16];
  logic [LogRawW-1:0] r_q [0:16];
  logic [31:0]        n_nz;
  logic [4:0]         msb;

  // Find the top set bit; zero counts as one
  always_comb begin
    n_nz = (n_i == '0) ? 32'd1 : n_i;
    msb  = '0;
    for (int i = 0; i < 32; i++) begin
      if (n_nz[i]) msb = 5'(i);
    end
  end

  // Normalise mantissa to Q1.31
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q[0] <= n_nz << (5'd31 - msb);
      r_q[0] <= {msb, 16'd0};
    end
  end

  // One fraction bit per stage by squaring
  for (genvar s = 1; s <= 16; s++) begin : g_sq
    logic [63:0] sq;
    logic [32:0] t;
    always_comb begin
      sq = m_q[s-1] * m_q[s-1];
      t  = sq[63:31];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (t[32]) begin
          m_q[s] <= t[32:1];
          r_q[s] <= r_q[s-1] | (LogRawW'(1) << (16 - s));
        end else begin
          m_q[s] <= t[31:0];
          r_q[s] <= r_q[s-1];
        end
      end
    end
  end

  assign r_o = r_q[16];

endmodule

/* sv/fpc_exp2.sv */
// Pipelined base-2 exponent lane giving a saturated Q32.16 value.
// Depends on fpc_pkg (table entries, widths).
`timescale 1ns / 1ps

module fpc_exp2 (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic signed [fpc_pkg::ExpW-1:0] e_i,
  input  logic                      keep_i,
  output logic [fpc_pkg::WideW-1:0] res_o
);
  import fpc_pkg::*;

  logic [XW-1:0]    x_q   [0:16];
  logic [31:0]      m_q   [0:16];
  exp_ctl_t         ctl_q [0:16];
  logic [WideW-1:0] res_q;
  logic signed [ExpW-1:0] x_full;
  logic [5:0]       ipart;
  logic [WideW-1:0] shifted;

  // Range checks and offset to a non-negative exponent
  always_comb x_full = e_i - ExpLo;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]      <= x_full[XW-1:0];
      m_q[0]      <= 32'h8000_0000;
      ctl_q[0]    <= '{sat: (e_i >= ExpHi), zero: (e_i < ExpLo), keep: keep_i};
    end
  end

  // One table multiply per fraction bit, most significant first
  for (genvar s = 1; s <= 16; s++) begin : g_mul
    localparam logic [31:0] RomS = rom_entry(s);
    logic [63:0] prod;
    always_comb prod = m_q[s-1] * RomS;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[s]   <= x_q[s-1];
        ctl_q[s] <= ctl_q[s-1];
        m_q[s]   <= x_q[s-1][16 - s] ? prod[62:31] : m_q[s-1];
      end
    end
  end

  // Apply the integer part
  always_comb begin
    ipart = x_q[16][XW-1:16];
    if (ipart >= 6'd31) shifted = WideW'(m_q[16]) << (ipart - 6'd31);
    else                shifted = WideW'(m_q[16]) >> (6'd31 - ipart);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (!ctl_q[16].keep)    res_q <= '0;
      else if (ctl_q[16].sat) res_q <= OutMax;
      else if (ctl_q[16].zero) res_q <= '0;
      else                    res_q <= shifted;
    end
  end

  assign res_o = res_q;

endmodule

/* sv/fpc_visc_div.sv */
// Viscosity lane: pressure times sine, then a radix-4 pipelined divide by density.
// Depends on fpc_pkg. Result shown from the last stage.
`timescale 1ns / 1ps

module fpc_visc_div (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [fpc_pkg::WideW-1:0] pfin_i,
  input  logic [fpc_pkg::FracW-1:0] sin_i,
  input  logic [fpc_pkg::RhoW-1:0]  rho_i,
  output logic [fpc_pkg::WideW-1:0] visc_o
);
  import fpc_pkg::*;

  localparam int Steps = WideW / 2;

  logic [63:0]      prod_q;
  logic [RhoW-1:0]  rho_p_q;
  logic [RhoW-1:0]  rem_q [0:Steps];
  logic [WideW-1:0] dq_q  [0:Steps];
  logic             sat_q [0:Steps];
  logic [RhoW-1:0]  rho_q [0:Steps];
  logic [54:0]      quo;

  // Form the dividend
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q  <= pfin_i * sin_i;
      rho_p_q <= rho_i;
    end
  end

  // Drop the 512 scale and check for overflow of the quotient
  always_comb quo = prod_q[63:9];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= RhoW'(quo[54:48]);
      dq_q[0]  <= quo[47:0];
      sat_q[0] <= (RhoW'(quo[54:48]) >= rho_p_q);
      rho_q[0] <= rho_p_q;
    end
  end

  // Two quotient bits per stage
  for (genvar s = 1; s <= Steps; s++) begin : g_div
    logic [RhoW:0]   r1, r2;
    logic            ge1, ge2;
    logic [RhoW-1:0] r1n, r2n;
    always_comb begin
      r1  = {rem_q[s-1], dq_q[s-1][WideW-1]};
      ge1 = r1 >= {1'b0, rho_q[s-1]};
      r1n = ge1 ? RhoW'(r1 - {1'b0, rho_q[s-1]}) : r1[RhoW-1:0];
      r2  = {r1n, dq_q[s-1][WideW-2]};
      ge2 = r2 >= {1'b0, rho_q[s-1]};
      r2n = ge2 ? RhoW'(r2 - {1'b0, rho_q[s-1]}) : r2[RhoW-1:0];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= r2n;
        dq_q[s]  <= {dq_q[s-1][WideW-3:0], ge1, ge2};
        sat_q[s] <= sat_q[s-1];
        rho_q[s] <= rho_q[s-1];
      end
    end
  end

  assign visc_o = sat_q[Steps] ? OutMax : dq_q[Steps];

endmodule

/* sv/frictional_pressure_cell_unit.sv */
// Top level of the frictional pressure unit: config registers, cell preparation,
// log/exp lanes and output stage. Depends on fpc_pkg, fpc_log2, fpc_exp2, fpc_visc_div.
// ----------------------------------------------------------------------------
// Usage
//   s_axis_*: one mesh cell per item. m_axis_*: pressure, slope and viscosity
//   for that cell, one result item per input item, in order.
//   cfg_*: register writes (index, data); always ready. Write only while the
//   pipeline holds no items.
// Throughput
//   One item per cycle sustained while no result waits with m_axis_tready low.
//   The depth is set by the 16-step squaring log lanes followed by the 16-step
//   table-multiply exp lanes; the viscosity divide runs alongside.
// Reset
//   Clears all valid bits and loads the register defaults; items can be
//   accepted in the first cycle after reset.
// Stall
//   While a result waits with m_axis_tready low, the whole pipeline holds and
//   s_axis_tready is low; when the output is empty or being taken, a new item
//   enters in the same cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frictional_pressure_cell_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // phase_fraction, continuous_fraction, max_packing, viscosity_pressure, density
  input  logic [fpc_pkg::InW-1:0]     s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // pressure, pressure_slope, viscosity
  output logic [fpc_pkg::OutW-1:0]    m_axis_tdata,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [fpc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [fpc_pkg::CfgW-1:0]    cfg_data_i
);
  import fpc_pkg::*;

  localparam int Depth = 40;

  // Configuration registers
  logic [FricW-1:0] fric_q;
  logic [15:0]      eta_q, p_q, mgap_q, onset_q, sine_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fric_q  <= 32'd3277;
      eta_q   <= 16'd8192;
      p_q     <= 16'd20480;
      mgap_q  <= 16'd3277;
      onset_q <= 16'd32768;
      sine_q  <= 16'd32768;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgFric:   fric_q  <= cfg_data_i;
        CfgEta:    eta_q   <= cfg_data_i[15:0];
        CfgP:      p_q     <= cfg_data_i[15:0];
        CfgMinGap: mgap_q  <= cfg_data_i[15:0];
        CfgOnset:  onset_q <= cfg_data_i[15:0];
        CfgSine:   sine_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Pipeline advance and valid bits
  logic             en;
  logic [Depth:1]   v_q;

  assign en            = !v_q[Depth] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = v_q[Depth];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[Depth-1:1], s_axis_tvalid};
    end
  end

  // Input fields
  logic [15:0]      in_alpha, in_cont, in_maxp;
  logic [WideW-1:0] in_pfin;
  logic [RhoW-1:0]  in_rho;

  assign in_alpha = s_axis_tdata[15:0];
  assign in_cont  = s_axis_tdata[31:16];
  assign in_maxp  = s_axis_tdata[47:32];
  assign in_pfin  = s_axis_tdata[95:48];
  assign in_rho   = s_axis_tdata[119:96];

  // Prepare the cell: solids total, excess, gap and phase difference
  logic [16:0]        total;
  logic signed [17:0] diff_s, gap_s, d_s;
  logic [15:0]        mg, gap;
  logic [16:0]        diff, mag;
  flags_t             flg_d;

  always_comb begin
    total  = 17'h10000 - {1'b0, in_cont};
    diff_s = $signed({1'b0, total}) - $signed({2'b0, onset_q});
    mg     = (mgap_q == '0) ? 16'd1 : mgap_q;
    gap_s  = $signed({2'b0, in_maxp}) - $signed({1'b0, total});
    gap    = (gap_s < $signed({2'b0, mg})) ? mg : gap_s[15:0];
    d_s    = $signed({1'b0, total}) - $signed({2'b0, in_alpha});
    flg_d.diff_pos  = !diff_s[17] && (diff_s != '0);
    flg_d.alpha_pos = (in_alpha != '0);
    flg_d.d_zero    = (d_s == '0);
    flg_d.d_neg     = d_s[17];
    diff   = flg_d.diff_pos ? diff_s[16:0] : '0;
    mag    = d_s[17] ? 17'(-d_s) : d_s[16:0];
  end

  logic [16:0]      tot_q, diff_q, mag_q;
  logic [15:0]      gap_q, alpha_q;
  logic [WideW-1:0] pfin_q;
  logic [RhoW-1:0]  rho_q;
  flags_t           flg_q [1:Depth-1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      tot_q    <= total;
      diff_q   <= diff;
      mag_q    <= mag;
      gap_q    <= gap;
      alpha_q  <= in_alpha;
      pfin_q   <= in_pfin;
      rho_q    <= (in_rho == '0) ? RhoW'(1) : in_rho;
      flg_q[1] <= flg_d;
    end
  end

  // Carry the flags alongside the lanes
  for (genvar s = 2; s <= Depth - 1; s++) begin : g_flg
    always_ff @(posedge clk_i) begin
      if (en) flg_q[s] <= flg_q[s-1];
    end
  end

  // Log lanes
  logic [LogRawW-1:0] r_tot, r_gap, r_alpha, r_fr, r_diff, r_eta, r_p, r_mag;

  fpc_log2 u_lg_tot   (.clk_i, .en_i(en), .n_i(32'(tot_q)),   .r_o(r_tot));
  fpc_log2 u_lg_gap   (.clk_i, .en_i(en), .n_i(32'(gap_q)),   .r_o(r_gap));
  fpc_log2 u_lg_alpha (.clk_i, .en_i(en), .n_i(32'(alpha_q)), .r_o(r_alpha));
  fpc_log2 u_lg_fr    (.clk_i, .en_i(en), .n_i(fric_q),       .r_o(r_fr));
  fpc_log2 u_lg_diff  (.clk_i, .en_i(en), .n_i(32'(diff_q)),  .r_o(r_diff));
  fpc_log2 u_lg_eta   (.clk_i, .en_i(en), .n_i(32'(eta_q)),   .r_o(r_eta));
  fpc_log2 u_lg_p     (.clk_i, .en_i(en), .n_i(32'(p_q)),     .r_o(r_p));
  fpc_log2 u_lg_mag   (.clk_i, .en_i(en), .n_i(32'(mag_q)),   .r_o(r_mag));

  // Remove Q offsets, scale the exponents
  logic signed [LogW-1:0]  c_tot, c_gap, c_diff;
  logic signed [LogW-1:0]  ltot_q, lgap_q, lalpha_q, lfr_q, ldiff_q, lmag_q, qeta_q, qp_q;
  logic signed [ProdW-1:0] pm_q, em_q;

  always_comb begin
    c_tot  = $signed(LogW'(r_tot)) - Shift16;
    c_gap  = $signed(LogW'(r_gap)) - Shift16;
    c_diff = $signed(LogW'(r_diff)) - Shift16;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ltot_q   <= c_tot;
      lgap_q   <= c_gap;
      ldiff_q  <= c_diff;
      lalpha_q <= $signed(LogW'(r_alpha)) - Shift16;
      lfr_q    <= $signed(LogW'(r_fr)) - Shift16;
      lmag_q   <= $signed(LogW'(r_mag)) - Shift16;
      qeta_q   <= $signed(LogW'(r_eta)) - Shift12;
      qp_q     <= $signed(LogW'(r_p)) - Shift12;
      pm_q     <= $signed({1'b0, p_q}) * c_gap;
      em_q     <= $signed({1'b0, eta_q}) * c_diff;
    end
  end

  // Base pressure exponent and partial sums
  logic signed [ExpW-1:0] lbase, lbase_q, lp_q, sat_q, qa_q, qb_q, qc_q;

  always_comb lbase = ExpW'(lfr_q) - pm_q[ExpW+11:12];

  always_ff @(posedge clk_i) begin
    if (en) begin
      lbase_q <= lbase;
      lp_q    <= flg_q[19].diff_pos ? lbase + em_q[ExpW+11:12] : lbase;
      sat_q   <= ExpW'(lalpha_q) - ExpW'(ltot_q);
      qa_q    <= ExpW'(lmag_q) - (ExpW'(ltot_q) <<< 1);
      qb_q    <= ExpW'(qeta_q) - ExpW'(ldiff_q);
      qc_q    <= ExpW'(qp_q) - ExpW'(lgap_q);
    end
  end

  // Final exponents and which terms exist
  logic fr_nz, eta_zero, eta_one, p_pos, has_p;
  flags_t f20;
  logic signed [ExpW-1:0] epres_q, ea_q, eb_q, ec_q;
  logic kpres_q, ka_q, kb_q, kc_q;

  always_comb begin
    fr_nz    = (fric_q != '0);
    eta_zero = (eta_q == '0);
    eta_one  = (eta_q == OneQ12);
    p_pos    = (p_q != '0);
    f20      = flg_q[20];
    has_p    = fr_nz && (f20.diff_pos || eta_zero);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      epres_q <= lp_q + sat_q;
      ea_q    <= lp_q + qa_q;
      ec_q    <= sat_q + lp_q + qc_q;
      eb_q    <= f20.diff_pos ? sat_q + lp_q + qb_q : sat_q + lbase_q;
      kpres_q <= has_p && f20.alpha_pos;
      ka_q    <= has_p && !f20.d_zero;
      kc_q    <= has_p && f20.alpha_pos && p_pos;
      kb_q    <= fr_nz && f20.alpha_pos && (f20.diff_pos ? !eta_zero : eta_one);
    end
  end

  // Exp lanes
  logic [WideW-1:0] t_pres, t_a, t_b, t_c;

  fpc_exp2 u_ex_pres (.clk_i, .en_i(en), .e_i(epres_q), .keep_i(kpres_q), .res_o(t_pres));
  fpc_exp2 u_ex_a    (.clk_i, .en_i(en), .e_i(ea_q),    .keep_i(ka_q),    .res_o(t_a));
  fpc_exp2 u_ex_b    (.clk_i, .en_i(en), .e_i(eb_q),    .keep_i(kb_q),    .res_o(t_b));
  fpc_exp2 u_ex_c    (.clk_i, .en_i(en), .e_i(ec_q),    .keep_i(kc_q),    .res_o(t_c));

  // Viscosity lane, delayed to meet the others
  logic [WideW-1:0] visc_div;
  logic [WideW-1:0] visc_q [28:Depth-1];

  fpc_visc_div u_visc (
    .clk_i,
    .en_i  (en),
    .pfin_i(pfin_q),
    .sin_i (sine_q),
    .rho_i (rho_q),
    .visc_o(visc_div)
  );

  always_ff @(posedge clk_i) begin
    if (en) visc_q[28] <= visc_div;
  end

  for (genvar s = 29; s <= Depth - 1; s++) begin : g_visc
    always_ff @(posedge clk_i) begin
      if (en) visc_q[s] <= visc_q[s-1];
    end
  end

  // Sum the slope terms and clamp
  flags_t                 f39;
  logic                   sat_b;
  logic [WideW-1:0]       bterm, slope_d;
  logic signed [WideW+2:0] sa, ssum;
  logic [WideW-1:0]       pres_out_q, slope_out_q, visc_out_q;

  always_comb begin
    f39   = flg_q[Depth-1];
    sat_b = fr_nz && !f39.diff_pos && f39.alpha_pos && !eta_zero && (eta_q < OneQ12);
    bterm = sat_b ? OutMax : t_b;
    sa    = f39.d_neg ? -$signed({3'b0, t_a}) : $signed({3'b0, t_a});
    ssum  = sa + $signed({3'b0, bterm}) + $signed({3'b0, t_c});
    if (ssum[WideW+2])                          slope_d = '0;
    else if (ssum > $signed({3'b0, OutMax}))    slope_d = OutMax;
    else                                        slope_d = ssum[WideW-1:0];
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (en) begin
      pres_out_q  <= t_pres;
      slope_out_q <= slope_d;
      visc_out_q  <= visc_q[Depth-1];
    end
  end

  assign m_axis_tdata = {visc_out_q, slope_out_q, pres_out_q};

`ifndef SYNTHESIS
  // Hold every valid bit while the pipeline is stalled
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(v_q))
    else $error("valid bits moved during a stall");

  // The last stage takes the valid of the one before it when advancing
  a_last_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en |=> (v_q[Depth] == $past(v_q[Depth-1])))
    else $error("output valid lost or invented");

  // A phase with no fraction carries no pressure at the exp lane output
  a_zero_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[Depth-1] && !flg_q[Depth-1].alpha_pos) |-> (t_pres == '0))
    else $error("pressure for an empty phase");
`endif

endmodule
